// File: rtl/chip8_instruction_core_assert.svh
// Assertion macros used by the RTL data path module.
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C8IC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C8IC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/c8ic_pkg.sv
`default_nettype none
package c8ic_pkg;

  localparam int MEM_BYTES    = 4096;
  localparam int MEM_AW       = $clog2(MEM_BYTES);
  localparam int FONT_BYTES   = 80;
  localparam int FB_ROWS      = 32;
  localparam int FB_COLS      = 64;
  localparam int DEF_STACK_DEPTH = 16;

  localparam logic [11:0] START_RESET = 12'd512;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_AW     = 3;
  localparam logic [CFG_AW-1:0] REG_START_ADDRESS = 3'd0;

  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_ROW   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [1:0] STAT_INVALID   = 2'd3;

  localparam logic [3:0] OPG_SYS    = 4'h0;
  localparam logic [3:0] OPG_JP     = 4'h1;
  localparam logic [3:0] OPG_CALL   = 4'h2;
  localparam logic [3:0] OPG_SE_NN  = 4'h3;
  localparam logic [3:0] OPG_SNE_NN = 4'h4;
  localparam logic [3:0] OPG_SE_V   = 4'h5;
  localparam logic [3:0] OPG_LD_NN  = 4'h6;
  localparam logic [3:0] OPG_ADD_NN = 4'h7;
  localparam logic [3:0] OPG_ALU    = 4'h8;
  localparam logic [3:0] OPG_SNE_V  = 4'h9;
  localparam logic [3:0] OPG_LD_I   = 4'hA;
  localparam logic [3:0] OPG_JP_V0  = 4'hB;
  localparam logic [3:0] OPG_RND    = 4'hC;
  localparam logic [3:0] OPG_DRAW   = 4'hD;
  localparam logic [3:0] OPG_KEY    = 4'hE;
  localparam logic [3:0] OPG_MISC   = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KEY_DOWN = 8'h9E;
  localparam logic [7:0] KEY_UP   = 8'hA1;

  localparam logic [7:0] FN_GET_DT  = 8'h07;
  localparam logic [7:0] FN_WAITKEY = 8'h0A;
  localparam logic [7:0] FN_SET_DT  = 8'h15;
  localparam logic [7:0] FN_SET_ST  = 8'h18;
  localparam logic [7:0] FN_ADD_I   = 8'h1E;
  localparam logic [7:0] FN_FONT    = 8'h29;
  localparam logic [7:0] FN_BCD     = 8'h33;
  localparam logic [7:0] FN_STORE   = 8'h55;
  localparam logic [7:0] FN_LOAD    = 8'h65;

  typedef enum logic [4:0] {
    C_NONE, C_CLR, C_ACCEPT, C_ONE, C_FETCH0, C_FETCH1, C_FETCH2, C_REGRD,
    C_EXEC, C_DRAW_RD, C_DRAW_WR, C_BCD, C_STORE_RD, C_STORE_WR,
    C_LOAD_RD, C_LOAD_WR, C_WRVF, C_RESP
  } cmd_t;

  typedef enum logic [2:0] {
    SQ_NONE, SQ_VF, SQ_DRAW, SQ_BCD, SQ_STORE, SQ_LOAD
  } seq_t;

  typedef struct packed {
    logic clr_last;
    seq_t seq;
    logic draw_empty;
    logic draw_last;
    logic bcd_last;
    logic blk_last;
    logic out_free;
  } sts_t;

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
    logic [7:0] b;
    b = 8'd0;
    if (a < MEM_AW'(FONT_BYTES)) begin
      b = FONT_ROM[a[6:0]];
    end
    return b;
  endfunction

  // Shift-and-add-three conversion: hundreds, tens and ones from the top down.
  function automatic logic [11:0] bcd_of(input logic [7:0] v);
    logic [19:0] s;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = s << 1;
    end
    return s[19:8];
  endfunction

endpackage
`default_nettype wire

// File: rtl/c8ic_ctrl.sv
`default_nettype none
module c8ic_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic [1:0]    in_kind,
  input  wire c8ic_pkg::sts_t sts,
  output logic               in_tready,
  output c8ic_pkg::cmd_t     cmd
);
  import c8ic_pkg::*;

  typedef enum logic [16:0] {
    ST_CLR      = 17'b00000000000000001,
    ST_IDLE     = 17'b00000000000000010,
    ST_ONE      = 17'b00000000000000100,
    ST_FETCH0   = 17'b00000000000001000,
    ST_FETCH1   = 17'b00000000000010000,
    ST_FETCH2   = 17'b00000000000100000,
    ST_REGRD    = 17'b00000000001000000,
    ST_EXEC     = 17'b00000000010000000,
    ST_DRAW_RD  = 17'b00000000100000000,
    ST_DRAW_WR  = 17'b00000001000000000,
    ST_BCD      = 17'b00000010000000000,
    ST_STORE_RD = 17'b00000100000000000,
    ST_STORE_WR = 17'b00001000000000000,
    ST_LOAD_RD  = 17'b00010000000000000,
    ST_LOAD_WR  = 17'b00100000000000000,
    ST_WRVF     = 17'b01000000000000000,
    ST_RESP     = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = C_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cmd = C_CLR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = C_ACCEPT;
          state_nxt = (in_kind == KIND_EXEC) ? ST_FETCH0 : ST_ONE;
        end
      end
      ST_ONE: begin
        cmd       = C_ONE;
        state_nxt = ST_RESP;
      end
      ST_FETCH0: begin
        cmd       = C_FETCH0;
        state_nxt = ST_FETCH1;
      end
      ST_FETCH1: begin
        cmd       = C_FETCH1;
        state_nxt = ST_FETCH2;
      end
      ST_FETCH2: begin
        cmd       = C_FETCH2;
        state_nxt = ST_REGRD;
      end
      ST_REGRD: begin
        cmd       = C_REGRD;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd = C_EXEC;
        case (sts.seq)
          SQ_VF:    state_nxt = ST_WRVF;
          SQ_DRAW:  state_nxt = sts.draw_empty ? ST_WRVF : ST_DRAW_RD;
          SQ_BCD:   state_nxt = ST_BCD;
          SQ_STORE: state_nxt = ST_STORE_RD;
          SQ_LOAD:  state_nxt = ST_LOAD_RD;
          default:  state_nxt = ST_RESP;
        endcase
      end
      ST_DRAW_RD: begin
        cmd       = C_DRAW_RD;
        state_nxt = ST_DRAW_WR;
      end
      ST_DRAW_WR: begin
        cmd       = C_DRAW_WR;
        state_nxt = sts.draw_last ? ST_WRVF : ST_DRAW_RD;
      end
      ST_BCD: begin
        cmd = C_BCD;
        if (sts.bcd_last) state_nxt = ST_RESP;
      end
      ST_STORE_RD: begin
        cmd       = C_STORE_RD;
        state_nxt = ST_STORE_WR;
      end
      ST_STORE_WR: begin
        cmd       = C_STORE_WR;
        state_nxt = sts.blk_last ? ST_RESP : ST_STORE_RD;
      end
      ST_LOAD_RD: begin
        cmd       = C_LOAD_RD;
        state_nxt = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd       = C_LOAD_WR;
        state_nxt = sts.blk_last ? ST_RESP : ST_LOAD_RD;
      end
      ST_WRVF: begin
        cmd       = C_WRVF;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd       = C_RESP;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/c8ic_dpath.sv
`default_nettype none
`include "chip8_instruction_core_assert.svh"
module c8ic_dpath #(
  parameter int STACK_DEPTH = c8ic_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire c8ic_pkg::cmd_t                 cmd,
  output c8ic_pkg::sts_t                      sts,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [c8ic_pkg::IN_DATA_W-1:0] in_data,
  input  wire logic                           cfg_we,
  input  wire logic [11:0]                    cfg_data,
  output logic [11:0]                         start_value,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic [c8ic_pkg::OUT_DATA_W-1:0]     out_data
);
  import c8ic_pkg::*;

  localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  regs [16];
  logic [11:0] stack [STACK_DEPTH];
  logic [63:0] fb [FB_ROWS];

  logic [1:0]  kind_r;
  logic [11:0] laddr_r;
  logic [7:0]  ldata_r;
  logic [15:0] keys_r;
  logic [7:0]  rnd_r;
  logic [4:0]  rowsel_r;

  logic [11:0] start_r, pc_r;
  logic [15:0] idx_r, op_r;
  logic [7:0]  dly_r, snd_r, vf_r, va_r, vb_r, mem_q_r, f_r;
  logic [11:0] stk_q_r;
  logic [63:0] fb_rd_r;
  logic        fb_rv_r;
  logic [FB_ROWS-1:0] fb_valid_r;
  logic [LVL_W-1:0]   level_r;
  logic [3:0]  k_r;
  logic [MEM_AW-1:0] clr_r;
  logic [1:0]  stat_r;
  logic        wait_r;
  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [63:0] fb_q, mask;
  logic [11:0] ik_addr, bcd;
  logic [LVL_W-1:0] lvl_m1;

  logic [11:0] ex_next;
  logic [1:0]  ex_stat;
  logic        ex_wait, ex_rwe, ex_idx_we, ex_dly_we, ex_snd_we, ex_push, ex_pop, ex_cls;
  logic [7:0]  ex_rwd, ex_f;
  logic [15:0] ex_idx;
  seq_t        ex_seq;
  logic [8:0]  sum9;
  logic [3:0]  key_first;

  logic [MEM_AW-1:0] mem_ra, mem_wa;
  logic        mem_we;
  logic [7:0]  mem_wd;
  logic [3:0]  reg_wa, reg_ra, reg_rb;
  logic        reg_we;
  logic [7:0]  reg_wd;
  logic [4:0]  fb_ra;

  assign x   = op_r[11:8];
  assign y   = op_r[7:4];
  assign n   = op_r[3:0];
  assign nn  = op_r[7:0];
  assign nnn = op_r[11:0];

  assign ik_addr = idx_r[11:0] + {8'd0, k_r};
  assign fb_q    = fb_rv_r ? fb_rd_r : 64'd0;
  assign mask    = {mem_q_r, 56'd0} >> va_r[5:0];
  assign bcd     = bcd_of(va_r);
  assign lvl_m1  = level_r - LVL_W'(1);
  assign sum9    = {1'b0, va_r} + {1'b0, vb_r};

  always_comb begin
    key_first = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_r[i]) key_first = 4'(i);
    end
  end

  always_comb begin
    ex_next   = pc_r + 12'd2;
    ex_stat   = STAT_OK;
    ex_wait   = 1'b0;
    ex_rwe    = 1'b0;
    ex_rwd    = 8'd0;
    ex_f      = 8'd0;
    ex_idx    = idx_r;
    ex_idx_we = 1'b0;
    ex_dly_we = 1'b0;
    ex_snd_we = 1'b0;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_cls    = 1'b0;
    ex_seq    = SQ_NONE;
    case (op_r[15:12])
      OPG_SYS: begin
        if (op_r == OP_CLS) begin
          ex_cls = 1'b1;
        end else if (op_r == OP_RET) begin
          if (level_r == '0) begin
            ex_stat = STAT_UNDERFLOW;
          end else begin
            ex_pop  = 1'b1;
            ex_next = stk_q_r + 12'd2;
          end
        end
      end
      OPG_JP: ex_next = nnn;
      OPG_CALL: begin
        if (level_r >= LVL_W'(STACK_DEPTH)) begin
          ex_stat = STAT_OVERFLOW;
        end else begin
          ex_push = 1'b1;
          ex_next = nnn;
        end
      end
      OPG_SE_NN:  if (va_r == nn) ex_next = pc_r + 12'd4;
      OPG_SNE_NN: if (va_r != nn) ex_next = pc_r + 12'd4;
      OPG_SE_V:   if (va_r == vb_r) ex_next = pc_r + 12'd4;
      OPG_SNE_V:  if (va_r != vb_r) ex_next = pc_r + 12'd4;
      OPG_LD_NN: begin
        ex_rwe = 1'b1;
        ex_rwd = nn;
      end
      OPG_ADD_NN: begin
        ex_rwe = 1'b1;
        ex_rwd = va_r + nn;
      end
      OPG_ALU: begin
        ex_rwe = 1'b1;
        ex_seq = SQ_VF;
        case (n)
          ALU_MOV: begin ex_rwd = vb_r; ex_seq = SQ_NONE; end
          ALU_OR:  begin ex_rwd = va_r | vb_r; ex_seq = SQ_NONE; end
          ALU_AND: begin ex_rwd = va_r & vb_r; ex_seq = SQ_NONE; end
          ALU_XOR: begin ex_rwd = va_r ^ vb_r; ex_seq = SQ_NONE; end
          ALU_ADD: begin ex_rwd = sum9[7:0]; ex_f = {7'd0, sum9[8]}; end
          ALU_SUB: begin ex_rwd = va_r - vb_r; ex_f = {7'd0, va_r >= vb_r}; end
          ALU_SHR: begin ex_rwd = {1'b0, vb_r[7:1]}; ex_f = {7'd0, vb_r[0]}; end
          ALU_SBN: begin ex_rwd = vb_r - va_r; ex_f = {7'd0, vb_r >= va_r}; end
          ALU_SHL: begin ex_rwd = {vb_r[6:0], 1'b0}; ex_f = {7'd0, vb_r[7]}; end
          default: begin
            ex_rwe  = 1'b0;
            ex_seq  = SQ_NONE;
            ex_stat = STAT_INVALID;
          end
        endcase
      end
      OPG_LD_I: begin
        ex_idx    = {4'd0, nnn};
        ex_idx_we = 1'b1;
      end
      OPG_JP_V0: ex_next = nnn + {4'd0, va_r};
      OPG_RND: begin
        ex_rwe = 1'b1;
        ex_rwd = rnd_r & nn;
      end
      OPG_DRAW: ex_seq = SQ_DRAW;
      OPG_KEY: begin
        if (nn == KEY_DOWN) begin
          if (keys_r[va_r[3:0]]) ex_next = pc_r + 12'd4;
        end else if (nn == KEY_UP) begin
          if (!keys_r[va_r[3:0]]) ex_next = pc_r + 12'd4;
        end else begin
          ex_stat = STAT_INVALID;
        end
      end
      default: begin
        case (nn)
          FN_GET_DT: begin
            ex_rwe = 1'b1;
            ex_rwd = dly_r;
          end
          FN_WAITKEY: begin
            if (keys_r == 16'd0) begin
              ex_wait = 1'b1;
            end else begin
              ex_rwe = 1'b1;
              ex_rwd = {4'd0, key_first};
            end
          end
          FN_SET_DT: ex_dly_we = 1'b1;
          FN_SET_ST: ex_snd_we = 1'b1;
          FN_ADD_I: begin
            ex_idx    = idx_r + {8'd0, va_r};
            ex_idx_we = 1'b1;
          end
          FN_FONT: begin
            ex_idx    = {10'd0, va_r[3:0], 2'd0} + {12'd0, va_r[3:0]};
            ex_idx_we = 1'b1;
          end
          FN_BCD:   ex_seq = SQ_BCD;
          FN_STORE: ex_seq = SQ_STORE;
          FN_LOAD:  ex_seq = SQ_LOAD;
          default:  ex_stat = STAT_INVALID;
        endcase
      end
    endcase
  end

  always_comb begin
    mem_ra = pc_r;
    mem_we = 1'b0;
    mem_wa = ik_addr;
    mem_wd = vb_r;
    case (cmd)
      C_FETCH1:                 mem_ra = pc_r + 12'd1;
      C_DRAW_RD, C_LOAD_RD:     mem_ra = ik_addr;
      default:                  mem_ra = pc_r;
    endcase
    case (cmd)
      C_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = font_byte(clr_r);
      end
      C_ONE: begin
        mem_we = (kind_r == KIND_WRITE);
        mem_wa = laddr_r;
        mem_wd = ldata_r;
      end
      C_BCD: begin
        mem_we = 1'b1;
        case (k_r)
          4'd0:    mem_wd = {4'd0, bcd[11:8]};
          4'd1:    mem_wd = {4'd0, bcd[7:4]};
          default: mem_wd = {4'd0, bcd[3:0]};
        endcase
      end
      C_STORE_WR: mem_we = 1'b1;
      default:    mem_we = 1'b0;
    endcase
  end

  always_comb begin
    reg_we = 1'b0;
    reg_wa = x;
    reg_wd = ex_rwd;
    reg_ra = (op_r[15:12] == OPG_JP_V0) ? 4'd0 : x;
    reg_rb = (cmd == C_STORE_RD) ? k_r : y;
    case (cmd)
      C_CLR: begin
        reg_we = 1'b1;
        reg_wa = clr_r[3:0];
        reg_wd = 8'd0;
      end
      C_EXEC:    reg_we = ex_rwe && (ex_stat == STAT_OK);
      C_LOAD_WR: begin
        reg_we = 1'b1;
        reg_wa = k_r;
        reg_wd = mem_q_r;
      end
      C_WRVF: begin
        reg_we = 1'b1;
        reg_wa = 4'hF;
        reg_wd = f_r;
      end
      default: reg_we = 1'b0;
    endcase
    fb_ra = (cmd == C_ONE) ? rowsel_r : (vb_r[4:0] + {1'b0, k_r});
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (reg_we) regs[reg_wa] <= reg_wd;
    if (cmd == C_REGRD) va_r <= regs[reg_ra];
    if (cmd == C_REGRD || cmd == C_STORE_RD) vb_r <= regs[reg_rb];
  end

  always_ff @(posedge clk) begin
    if (cmd == C_EXEC && ex_push) stack[level_r[STK_AW-1:0]] <= pc_r;
    if (cmd == C_REGRD) stk_q_r <= stack[lvl_m1[STK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd == C_DRAW_WR) fb[fb_ra] <= fb_q ^ mask;
    if (cmd == C_ONE || cmd == C_DRAW_RD) begin
      fb_rd_r <= fb[fb_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == C_ACCEPT) begin
      kind_r   <= in_kind;
      laddr_r  <= in_data[11:0];
      ldata_r  <= in_data[19:12];
      keys_r   <= in_data[35:20];
      rnd_r    <= in_data[43:36];
      rowsel_r <= in_data[48:44];
    end
    if (cmd == C_FETCH1) op_r[15:8] <= mem_q_r;
    if (cmd == C_FETCH2) op_r[7:0] <= mem_q_r;
    if (cmd == C_EXEC) f_r <= ex_f;
    if (cmd == C_DRAW_WR && (fb_q & mask) != 64'd0) f_r <= 8'd1;
    if (cmd == C_RESP) begin
      out_r <= {(kind_r == KIND_ROW) ? fb_q : 64'd0, snd_r != 8'd0, vf_r,
                wait_r, stat_r, idx_r, pc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= START_RESET;
      pc_r        <= START_RESET;
      idx_r       <= '0;
      dly_r       <= '0;
      snd_r       <= '0;
      vf_r        <= '0;
      level_r     <= '0;
      k_r         <= '0;
      clr_r       <= '0;
      stat_r      <= STAT_OK;
      wait_r      <= 1'b0;
      fb_valid_r  <= '0;
      fb_rv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_data;
        pc_r    <= cfg_data;
      end
      if (reg_we && reg_wa == 4'hF) vf_r <= reg_wd;
      if (cmd == C_ONE || cmd == C_DRAW_RD) fb_rv_r <= fb_valid_r[fb_ra];
      if (cmd == C_DRAW_WR) fb_valid_r[fb_ra] <= 1'b1;
      if (cmd == C_RESP) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        C_CLR: clr_r <= clr_r + MEM_AW'(1);
        C_ACCEPT: begin
          stat_r <= STAT_OK;
          wait_r <= 1'b0;
          k_r    <= '0;
        end
        C_ONE: begin
          if (kind_r == KIND_TICK) begin
            if (dly_r != 8'd0) dly_r <= dly_r - 8'd1;
            if (snd_r != 8'd0) snd_r <= snd_r - 8'd1;
          end
        end
        C_EXEC: begin
          stat_r <= ex_stat;
          wait_r <= ex_wait;
          if (ex_stat == STAT_OK) begin
            if (!ex_wait) pc_r <= ex_next;
            if (ex_idx_we) idx_r <= ex_idx;
            if (ex_dly_we) dly_r <= va_r;
            if (ex_snd_we) snd_r <= va_r;
            if (ex_push) level_r <= level_r + LVL_W'(1);
            if (ex_pop) level_r <= lvl_m1;
            if (ex_cls) fb_valid_r <= '0;
          end
        end
        C_DRAW_WR, C_BCD, C_STORE_WR, C_LOAD_WR: k_r <= k_r + 4'd1;
        default: k_r <= k_r;
      endcase
    end
  end

  assign sts.clr_last   = (clr_r == {MEM_AW{1'b1}});
  assign sts.seq        = (ex_stat == STAT_OK) ? ex_seq : SQ_NONE;
  assign sts.draw_empty = (n == 4'd0);
  assign sts.draw_last  = (k_r == n - 4'd1) ||
                          (({1'b0, vb_r[4:0]} + {2'd0, k_r}) == 6'd31);
  assign sts.bcd_last   = (k_r == 4'd2);
  assign sts.blk_last   = (k_r == x);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign start_value = start_r;
  assign out_tvalid  = out_valid_r;
  assign out_data    = out_r;

  `C8IC_ASSERT_NOW(a_resp_slot_free, cmd == C_RESP, !out_valid_r || out_tready, "result overwritten")
  `C8IC_ASSERT_NOW(a_level_bound, 1'b1, level_r <= LVL_W'(STACK_DEPTH), "stack level out of range")
  `C8IC_ASSERT_NOW(a_block_count, cmd == C_STORE_RD || cmd == C_LOAD_RD, k_r <= x, "block count past VX")
  `C8IC_ASSERT_NEXT(a_resp_shows, cmd == C_RESP, out_valid_r, "result not presented")

endmodule
`default_nettype wire

// File: rtl/chip8_instruction_core.sv
// CHIP-8 instruction core.
// Input stream: one transaction per item; in_tuser carries the kind (execute,
// timer tick, memory write, screen row read), in_tdata the other fields.
// Output stream: exactly one result transaction per input item, in order.
// Configuration: an APB-style port with one register, the start address at
// byte address 0; writing it also loads the program counter.
// After reset the memory is swept once to load the font and clear the rest;
// no input is taken during the sweep. An item is accepted only when the core
// is idle, one at a time. A tick, write or row read is handled in one state
// before its result is offered. An instruction is fetched with two byte reads,
// then its registers are read and it executes; a VF write, a sprite draw (a read
// and a write per row), BCD (a write per digit) or a register block move (a
// read and a write per register) may follow, with fetch, sprite and block moves
// sharing the one memory read port. The result waits in an output register
// while the receiver stalls, and the next item may already be accepted
// meanwhile; its own result waits until the register is emptied.
`default_nettype none
module chip8_instruction_core #(
  parameter int STACK_DEPTH = c8ic_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [11:0] load_address, [19:12] load_data, [35:20] keys_down,
  // [43:36] random_byte, [48:44] row_select, rest zero.
  input  wire logic [c8ic_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind.
  input  wire logic [1:0]                      in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [11:0] program_counter, [27:12] index_value, [29:28] status,
  // [30] waiting_key, [38:31] flag_value, [39] sound_on, [103:40] row_pixels.
  output logic [c8ic_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [c8ic_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import c8ic_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_we;
  logic [11:0] start_value;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_START_ADDRESS);
  assign cfg_prdata = (cfg_paddr == REG_START_ADDRESS) ? {20'd0, start_value} : 32'd0;

  c8ic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  c8ic_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_kind     (in_tuser),
    .in_data     (in_tdata),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_pwdata[11:0]),
    .start_value (start_value),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_data    (out_tdata)
  );

endmodule
`default_nettype wire

// File: tb/tb_chip8_instruction_core.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_chip8_instruction_core;
  import c8ic_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int ITEM_TARGET  = 450;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  rnd;
    logic [4:0]  row;
  } c8_item_t;

  typedef struct {
    logic [11:0] pc;
    logic [15:0] idx;
    logic [1:0]  status;
    logic        waiting;
    logic [7:0]  vf;
    logic        sound;
    logic [63:0] pixels;
  } c8_result_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  chip8_instruction_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  c8_item_t   pending_items[$];
  c8_result_t expected_results[$];
  int         failures;
  int         cycle_count;
  int         item_count;
  logic       calm;
  logic       in_taken;

  // Shadow machine state.
  logic [7:0]  sh_mem [MEM_BYTES];
  logic [7:0]  sh_v [16];
  logic [11:0] sh_stack [DEF_STACK_DEPTH];
  int          sh_level;
  logic [11:0] sh_pc;
  logic [15:0] sh_i;
  logic [7:0]  sh_dt;
  logic [7:0]  sh_st;
  logic [63:0] sh_fb [32];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic shadow_reset();
    for (int a = 0; a < MEM_BYTES; a++) sh_mem[a] = (a < FONT_BYTES) ? FONT_ROM[a] : 8'd0;
    for (int k = 0; k < 16; k++) sh_v[k] = 8'd0;
    for (int k = 0; k < DEF_STACK_DEPTH; k++) sh_stack[k] = 12'd0;
    for (int k = 0; k < 32; k++) sh_fb[k] = 64'd0;
    sh_level = 0;
    sh_pc = START_RESET;
    sh_i = 16'd0;
    sh_dt = 8'd0;
    sh_st = 8'd0;
  endtask

  task automatic execute_shadow(input logic [15:0] keys, input logic [7:0] rnd,
                                output logic [1:0] st, output logic waiting);
    logic [15:0] op;
    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy, f;
    logic [11:0] nxt;
    logic [63:0] mask;
    logic hit;
    int k;
    op = {sh_mem[sh_pc], sh_mem[12'(sh_pc + 12'd1)]};
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    nn = op[7:0];
    nxt = sh_pc + 12'd2;
    vx = sh_v[x];
    vy = sh_v[y];
    st = STAT_OK;
    waiting = 1'b0;
    case (op[15:12])
      OPG_SYS: begin
        if (op == OP_CLS) begin
          for (k = 0; k < 32; k++) sh_fb[k] = 64'd0;
        end else if (op == OP_RET) begin
          if (sh_level == 0) st = STAT_UNDERFLOW;
          else begin
            sh_level--;
            nxt = sh_stack[sh_level] + 12'd2;
          end
        end
      end
      OPG_JP: nxt = op[11:0];
      OPG_CALL: begin
        if (sh_level >= DEF_STACK_DEPTH) st = STAT_OVERFLOW;
        else begin
          sh_stack[sh_level] = sh_pc;
          sh_level++;
          nxt = op[11:0];
        end
      end
      OPG_SE_NN: if (vx == nn) nxt = nxt + 12'd2;
      OPG_SNE_NN: if (vx != nn) nxt = nxt + 12'd2;
      OPG_SE_V: if (vx == vy) nxt = nxt + 12'd2;
      OPG_LD_NN: sh_v[x] = nn;
      OPG_ADD_NN: sh_v[x] = vx + nn;
      OPG_ALU: begin
        case (n)
          ALU_MOV: sh_v[x] = vy;
          ALU_OR: sh_v[x] = vx | vy;
          ALU_AND: sh_v[x] = vx & vy;
          ALU_XOR: sh_v[x] = vx ^ vy;
          ALU_ADD: begin
            f = ({1'b0, vx} + {1'b0, vy} > 9'd255) ? 8'd1 : 8'd0;
            sh_v[x] = vx + vy;
            sh_v[15] = f;
          end
          ALU_SUB: begin
            f = (vx >= vy) ? 8'd1 : 8'd0;
            sh_v[x] = vx - vy;
            sh_v[15] = f;
          end
          ALU_SHR: begin
            f = {7'd0, vy[0]};
            sh_v[x] = vy >> 1;
            sh_v[15] = f;
          end
          ALU_SBN: begin
            f = (vy >= vx) ? 8'd1 : 8'd0;
            sh_v[x] = vy - vx;
            sh_v[15] = f;
          end
          ALU_SHL: begin
            f = {7'd0, vy[7]};
            sh_v[x] = vy << 1;
            sh_v[15] = f;
          end
          default: st = STAT_INVALID;
        endcase
      end
      OPG_SNE_V: if (vx != vy) nxt = nxt + 12'd2;
      OPG_LD_I: sh_i = {4'd0, op[11:0]};
      OPG_JP_V0: nxt = op[11:0] + {4'd0, sh_v[0]};
      OPG_RND: sh_v[x] = rnd & nn;
      OPG_DRAW: begin
        hit = 1'b0;
        for (k = 0; k < n; k++) begin
          if (int'(vy[4:0]) + k < 32) begin
            mask = {sh_mem[12'(sh_i + 16'(k))], 56'd0} >> vx[5:0];
            if ((sh_fb[int'(vy[4:0]) + k] & mask) != 64'd0) hit = 1'b1;
            sh_fb[int'(vy[4:0]) + k] ^= mask;
          end
        end
        sh_v[15] = {7'd0, hit};
      end
      OPG_KEY: begin
        if (nn == KEY_DOWN) begin
          if (keys[vx[3:0]]) nxt = nxt + 12'd2;
        end else if (nn == KEY_UP) begin
          if (!keys[vx[3:0]]) nxt = nxt + 12'd2;
        end else st = STAT_INVALID;
      end
      default: begin
        case (nn)
          FN_GET_DT: sh_v[x] = sh_dt;
          FN_WAITKEY: begin
            if (keys == 16'd0) waiting = 1'b1;
            else begin
              for (k = 15; k >= 0; k--) if (keys[k]) sh_v[x] = 8'(k);
            end
          end
          FN_SET_DT: sh_dt = vx;
          FN_SET_ST: sh_st = vx;
          FN_ADD_I: sh_i = sh_i + {8'd0, vx};
          FN_FONT: sh_i = {12'd0, vx[3:0]} * 16'd5;
          FN_BCD: begin
            sh_mem[12'(sh_i)] = vx / 8'd100;
            sh_mem[12'(sh_i + 16'd1)] = (vx / 8'd10) % 8'd10;
            sh_mem[12'(sh_i + 16'd2)] = vx % 8'd10;
          end
          FN_STORE: for (k = 0; k <= x; k++) sh_mem[12'(sh_i + 16'(k))] = sh_v[k];
          FN_LOAD: for (k = 0; k <= x; k++) sh_v[k] = sh_mem[12'(sh_i + 16'(k))];
          default: st = STAT_INVALID;
        endcase
      end
    endcase
    if (st == STAT_OK && !waiting) sh_pc = nxt;
  endtask

  task automatic send(input c8_item_t it);
    c8_result_t r;
    r.status = STAT_OK;
    r.waiting = 1'b0;
    r.pixels = 64'd0;
    case (it.kind)
      KIND_EXEC: execute_shadow(it.keys, it.rnd, r.status, r.waiting);
      KIND_TICK: begin
        if (sh_dt != 8'd0) sh_dt--;
        if (sh_st != 8'd0) sh_st--;
      end
      KIND_WRITE: sh_mem[it.addr] = it.data;
      default: r.pixels = sh_fb[it.row];
    endcase
    r.pc = sh_pc;
    r.idx = sh_i;
    r.vf = sh_v[15];
    r.sound = (sh_st != 8'd0);
    pending_items.push_back(it);
    expected_results.push_back(r);
    item_count++;
  endtask

  task automatic send_simple(input logic [1:0] kind, input logic [11:0] addr,
                             input logic [7:0] data, input logic [4:0] row);
    c8_item_t it;
    it.kind = kind;
    it.addr = addr;
    it.data = data;
    it.keys = 16'($urandom);
    it.rnd = 8'($urandom);
    it.row = row;
    send(it);
  endtask

  task automatic run_instruction(input logic [15:0] op, input logic [15:0] keys);
    c8_item_t it;
    send_simple(KIND_WRITE, sh_pc, op[15:8], 5'($urandom));
    send_simple(KIND_WRITE, sh_pc + 12'd1, op[7:0], 5'($urandom));
    it.kind = KIND_EXEC;
    it.addr = 12'($urandom);
    it.data = 8'($urandom);
    it.keys = keys;
    it.rnd = 8'($urandom);
    it.row = 5'($urandom);
    send(it);
  endtask

  function automatic logic [15:0] random_keys();
    logic [15:0] k;
    case ($urandom_range(3))
      0: k = 16'd0;
      1: k = 16'd1 << $urandom_range(15);
      default: k = 16'($urandom);
    endcase
    return k;
  endfunction

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    logic [7:0] fn_list [9];
    logic [3:0] alu_list [9];
    fn_list = '{FN_GET_DT, FN_WAITKEY, FN_SET_DT, FN_SET_ST, FN_ADD_I, FN_FONT,
                FN_BCD, FN_STORE, FN_LOAD};
    alu_list = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                 ALU_SBN, ALU_SHL};
    op = 16'($urandom);
    case (op[15:12])
      OPG_SYS: begin
        case ($urandom_range(3))
          0: op = OP_CLS;
          1, 2: op = OP_RET;
          default: ;
        endcase
      end
      OPG_ALU: if ($urandom_range(7) != 0) op[3:0] = alu_list[$urandom_range(8)];
      OPG_DRAW: if ($urandom_range(1) == 0) op[3:0] = 4'($urandom_range(6));
      OPG_KEY: if ($urandom_range(7) != 0) op[7:0] = $urandom_range(1) ? KEY_DOWN : KEY_UP;
      OPG_MISC: if ($urandom_range(7) != 0) op[7:0] = fn_list[$urandom_range(8)];
      default: ;
    endcase
    return op;
  endfunction

  task automatic random_item();
    case ($urandom_range(9))
      0: send_simple(KIND_TICK, 12'($urandom), 8'($urandom), 5'($urandom));
      1: send_simple(KIND_WRITE, 12'($urandom), 8'($urandom), 5'($urandom));
      2: send_simple(KIND_ROW, 12'($urandom), 8'($urandom), 5'($urandom));
      default: run_instruction(random_opcode(), random_keys());
    endcase
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_start(input logic [11:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= REG_START_ADDRESS;
    cfg_pwdata <= {20'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sh_pc = value;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  // Stimulus.
  initial begin
    logic [11:0] starts [4];
    int phase_end;
    int quota;
    failures = 0;
    item_count = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_EXEC;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    shadow_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: stack faults, arithmetic flags, invalid codes, keys, BCD, draw.
    run_instruction(OP_RET, 16'h0000);
    run_instruction(OP_CLS, 16'hFFFF);
    run_instruction(16'h0123, 16'h0000);
    run_instruction(16'h6AFF, 16'h0000);
    run_instruction(16'h6B01, 16'h0000);
    run_instruction(16'h8AB4, 16'h0000);
    run_instruction(16'h8AB5, 16'h0000);
    run_instruction(16'h8FB6, 16'h0000);
    run_instruction(16'h8AB7, 16'h0000);
    run_instruction(16'h8FAE, 16'h0000);
    run_instruction(16'h8AB8, 16'h0000);
    run_instruction(16'hE09E, 16'h0001);
    run_instruction(16'hE0A1, 16'h0001);
    run_instruction(16'hE0FF, 16'h0000);
    run_instruction(16'hF30A, 16'h0000);
    run_instruction(16'hF30A, 16'h8000);
    run_instruction(16'hFF99, 16'h0000);
    run_instruction(16'hAFFE, 16'h0000);
    run_instruction(16'hFA33, 16'h0000);
    run_instruction(16'hFA18, 16'h0000);
    run_instruction(16'h603C, 16'h0000);
    run_instruction(16'h611E, 16'h0000);
    run_instruction(16'hFB29, 16'h0000);
    run_instruction(16'hD01F, 16'h0000);
    run_instruction(16'hD01F, 16'h0000);
    for (int k = 0; k <= DEF_STACK_DEPTH; k++) run_instruction({4'h2, 12'($urandom)}, 16'h0);
    for (int k = 0; k <= DEF_STACK_DEPTH; k++) run_instruction(OP_RET, 16'h0);
    send_simple(KIND_ROW, 12'd0, 8'd0, 5'd30);
    send_simple(KIND_ROW, 12'd0, 8'd0, 5'd31);
    for (int k = 0; k < 3; k++) send_simple(KIND_TICK, 12'd0, 8'd0, 5'd0);
    wait_drained();

    quota = (ITEM_TARGET - item_count) / 4;
    starts = '{12'd0, 12'hFFF, 12'($urandom), START_RESET};
    for (int p = 0; p < 4; p++) begin
      write_start(starts[p]);
      calm = (p == 2);
      phase_end = item_count + quota;
      while (item_count < phase_end) begin
        random_item();
        if (p == 1 && item_count > phase_end - quota / 2 && item_count < phase_end - quota / 4)
        begin
          wait_drained();
        end
      end
      wait_drained();
    end

    if (failures == 0) begin
      $display("chip8_instruction_core test passed");
    end else begin
      $display("chip8_instruction_core test failed");
    end
    $finish;
  end

  // Input driver.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
  end

  always @(negedge clk) begin
    c8_item_t it;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
        it = pending_items.pop_front();
        in_tuser <= it.kind;
        in_tdata <= {7'd0, it.row, it.rnd, it.keys, it.data, it.addr};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && (calm || $urandom_range(99) >= 37);
  end

  // Result checker.
  always @(posedge clk) begin
    c8_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %h", $time,
                 out_tdata);
        failures++;
      end else begin
        e = expected_results.pop_front();
        check_field("program_counter", 64'(e.pc), 64'(out_tdata[11:0]));
        check_field("index_value", 64'(e.idx), 64'(out_tdata[27:12]));
        check_field("status", 64'(e.status), 64'(out_tdata[29:28]));
        check_field("waiting_key", 64'(e.waiting), 64'(out_tdata[30]));
        check_field("flag_value", 64'(e.vf), 64'(out_tdata[38:31]));
        check_field("sound_on", 64'(e.sound), 64'(out_tdata[39]));
        check_field("row_pixels", e.pixels, out_tdata[103:40]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("chip8_instruction_core test failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
`default_nettype wire
